// ----- rtl/met_pkg.sv -----
package met_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int ITER_BITS  = 16;
    localparam int WORD_BITS  = 36;
    localparam int STEP_BITS  = 35;
    localparam int ESC_BITS   = 35;
    localparam int SHADE_BITS = 8;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int LO_BITS   = WORD_BITS / 2;
    localparam int HI_BITS   = WORD_BITS - LO_BITS;
    localparam int PART_BITS = LO_BITS + 1;
    localparam int MAP_BITS  = COORD_BITS + STEP_BITS;
    localparam int MAG_BITS  = WORD_BITS + 1;

    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 6;
    localparam int ADDR_LSB      = 3;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - ADDR_LSB;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_BITS-1:0] t_wide;

    localparam logic [ITER_BITS-1:0]  ITER_LIMIT_RST   = ITER_BITS'(300);
    localparam logic [ESC_BITS-1:0]   ESC_SQUARE_RST   = ESC_BITS'(536870912);
    localparam t_word                 ORIGIN_REAL_RST  = -36'sd671088640;
    localparam t_word                 ORIGIN_IMAG_RST  = -36'sd536870912;
    localparam logic [STEP_BITS-1:0]  STEP_REAL_RST    = STEP_BITS'(1789570);
    localparam logic [STEP_BITS-1:0]  STEP_IMAG_RST    = STEP_BITS'(1789570);
    localparam logic [SHADE_BITS-1:0] INSIDE_SHADE_RST = SHADE_BITS'(150);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_ITER_LIMIT   = 3'd0,
        REG_ESC_SQUARE   = 3'd1,
        REG_ORIGIN_REAL  = 3'd2,
        REG_ORIGIN_IMAG  = 3'd3,
        REG_STEP_REAL    = 3'd4,
        REG_STEP_IMAG    = 3'd5,
        REG_INSIDE_SHADE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [ITER_BITS-1:0]  iter_limit;
        logic [ESC_BITS-1:0]   esc_square;
        t_word                 origin_real;
        t_word                 origin_imag;
        logic [STEP_BITS-1:0]  step_real;
        logic [STEP_BITS-1:0]  step_imag;
        logic [SHADE_BITS-1:0] inside_shade;
    } t_cfg;

    typedef enum logic [1:0] {
        MS_XY,
        MS_XX,
        MS_YY
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     map;
        logic     clamp;
        logic     snap;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     upd;
        logic     set_zx2;
        logic     set_zy2;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic go;
        logic mul_done;
    } t_dp_sts;

    function automatic t_word sat_word(input t_wide v);
        t_wide hi_lim;
        t_wide lo_lim;
        t_word res;
        hi_lim = t_wide'({1'b0, {(WORD_BITS-1){1'b1}}});
        lo_lim = -hi_lim - t_wide'(1);
        if (v > hi_lim) begin
            res = hi_lim[WORD_BITS-1:0];
        end else if (v < lo_lim) begin
            res = lo_lim[WORD_BITS-1:0];
        end else begin
            res = v[WORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/met_regs.sv -----
module met_regs import met_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_BITS-1:ADDR_LSB]);
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iter_limit   <= ITER_LIMIT_RST;
            r_cfg.esc_square   <= ESC_SQUARE_RST;
            r_cfg.origin_real  <= ORIGIN_REAL_RST;
            r_cfg.origin_imag  <= ORIGIN_IMAG_RST;
            r_cfg.step_real    <= STEP_REAL_RST;
            r_cfg.step_imag    <= STEP_IMAG_RST;
            r_cfg.inside_shade <= INSIDE_SHADE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ITER_LIMIT:   r_cfg.iter_limit   <= pwdata[ITER_BITS-1:0];
                REG_ESC_SQUARE:   r_cfg.esc_square   <= pwdata[ESC_BITS-1:0];
                REG_ORIGIN_REAL:  r_cfg.origin_real  <= pwdata[WORD_BITS-1:0];
                REG_ORIGIN_IMAG:  r_cfg.origin_imag  <= pwdata[WORD_BITS-1:0];
                REG_STEP_REAL:    r_cfg.step_real    <= pwdata[STEP_BITS-1:0];
                REG_STEP_IMAG:    r_cfg.step_imag    <= pwdata[STEP_BITS-1:0];
                REG_INSIDE_SHADE: r_cfg.inside_shade <= pwdata[SHADE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ITER_LIMIT:   prdata = APB_DATA_BITS'(r_cfg.iter_limit);
            REG_ESC_SQUARE:   prdata = APB_DATA_BITS'(r_cfg.esc_square);
            REG_ORIGIN_REAL:  prdata = APB_DATA_BITS'(r_cfg.origin_real);
            REG_ORIGIN_IMAG:  prdata = APB_DATA_BITS'(r_cfg.origin_imag);
            REG_STEP_REAL:    prdata = APB_DATA_BITS'(r_cfg.step_real);
            REG_STEP_IMAG:    prdata = APB_DATA_BITS'(r_cfg.step_imag);
            REG_INSIDE_SHADE: prdata = APB_DATA_BITS'(r_cfg.inside_shade);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/met_fxmul.sv -----
module met_fxmul import met_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_res,
    output logic  o_done
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LO,
        PH_HI,
        PH_SUM
    } t_phase;

    t_phase                                r_phase;
    logic                                  r_done;
    t_word                                 r_a;
    t_word                                 r_b;
    t_word                                 r_res;
    logic signed [WORD_BITS+PART_BITS-1:0] r_plo;
    logic signed [WORD_BITS+PART_BITS-1:0] r_phi;
    logic signed [PART_BITS-1:0]           w_b_part;
    logic signed [WORD_BITS+PART_BITS-1:0] w_pp;
    t_wide                                 w_sum;
    t_wide                                 w_shift;

    always_comb begin
        if (r_phase == PH_LO) begin
            w_b_part = signed'({1'b0, r_b[LO_BITS-1:0]});
        end else begin
            w_b_part = signed'({{(PART_BITS-HI_BITS){r_b[WORD_BITS-1]}},
                                r_b[WORD_BITS-1:LO_BITS]});
        end
    end

    assign w_pp    = r_a * w_b_part;
    assign w_sum   = (t_wide'(r_phi) <<< LO_BITS) + t_wide'(r_plo);
    assign w_shift = w_sum >>> FRAC_BITS;
    assign o_res   = r_res;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: if (i_start) r_phase <= PH_LO;
                PH_LO:   r_phase <= PH_HI;
                PH_HI:   r_phase <= PH_SUM;
                PH_SUM: begin
                    r_phase <= PH_IDLE;
                    r_done  <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_phase == PH_LO) r_plo <= w_pp;
        if (r_phase == PH_HI) r_phi <= w_pp;
        if (r_phase == PH_SUM) r_res <= sat_word(w_shift);
    end

endmodule

// ----- rtl/met_datapath.sv -----
module met_datapath import met_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [COORD_BITS-1:0] i_pixel_col,
    input  logic [COORD_BITS-1:0] i_pixel_row,
    output logic [COORD_BITS-1:0] o_out_col,
    output logic [COORD_BITS-1:0] o_out_row,
    output logic                  o_inside_res,
    output logic [ITER_BITS-1:0]  o_iter_count,
    output logic [SHADE_BITS-1:0] o_shade
);

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [MAP_BITS-1:0]   r_pr;
    logic [MAP_BITS-1:0]   r_pi;
    t_word                 r_cx;
    t_word                 r_cy;
    t_word                 r_zx;
    t_word                 r_zy;
    t_word                 r_zx2;
    t_word                 r_zy2;
    logic [ITER_BITS-1:0]  r_cnt;
    logic [COORD_BITS-1:0] r_out_col;
    logic [COORD_BITS-1:0] r_out_row;
    logic                  r_out_inside;
    logic [ITER_BITS-1:0]  r_out_count;
    logic [SHADE_BITS-1:0] r_out_shade;

    t_word                 w_mul_a;
    t_word                 w_mul_b;
    t_word                 w_mul_res;
    logic                  w_mul_done;
    logic [WORD_BITS-1:0]  w_acy;
    logic                  w_snap;
    logic [MAG_BITS-1:0]   w_mag;
    logic                  w_inside;

    met_fxmul u_fxmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_res   (w_mul_res),
        .o_done  (w_mul_done)
    );

    always_comb begin
        case (i_cmd.mul_sel)
            MS_XX:   begin w_mul_a = r_zx; w_mul_b = r_zx; end
            MS_YY:   begin w_mul_a = r_zy; w_mul_b = r_zy; end
            default: begin w_mul_a = r_zx; w_mul_b = r_zy; end
        endcase
    end

    assign w_acy    = r_cy[WORD_BITS-1] ? (~r_cy) + WORD_BITS'(1) : r_cy;
    assign w_snap   = {w_acy, 1'b0} < {2'b00, i_cfg.step_imag};
    assign w_mag    = {1'b0, r_zx2} + {1'b0, r_zy2};
    assign w_inside = (r_cnt == i_cfg.iter_limit);

    assign o_sts.go       = (r_cnt < i_cfg.iter_limit) && (w_mag < {2'b00, i_cfg.esc_square});
    assign o_sts.mul_done = w_mul_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= i_pixel_col;
            r_row <= i_pixel_row;
        end
        if (i_cmd.map) begin
            r_pr <= r_col * i_cfg.step_real;
            r_pi <= r_row * i_cfg.step_imag;
        end
        if (i_cmd.clamp) begin
            r_cx <= sat_word(t_wide'(i_cfg.origin_real) + t_wide'({1'b0, r_pr}));
            r_cy <= sat_word(t_wide'(i_cfg.origin_imag) + t_wide'({1'b0, r_pi}));
        end
        if (i_cmd.snap) begin
            if (w_snap) r_cy <= '0;
            r_zx  <= '0;
            r_zy  <= '0;
            r_zx2 <= '0;
            r_zy2 <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.upd) begin
            r_zy <= sat_word((t_wide'(w_mul_res) <<< 1) + t_wide'(r_cy));
            r_zx <= sat_word(t_wide'(r_zx2) - t_wide'(r_zy2) + t_wide'(r_cx));
        end
        if (i_cmd.set_zx2) r_zx2 <= w_mul_res;
        if (i_cmd.set_zy2) begin
            r_zy2 <= w_mul_res;
            r_cnt <= r_cnt + ITER_BITS'(1);
        end
        if (i_cmd.load_out) begin
            r_out_col    <= r_col;
            r_out_row    <= r_row;
            r_out_inside <= w_inside;
            r_out_count  <= r_cnt;
            r_out_shade  <= w_inside ? i_cfg.inside_shade : '0;
        end
    end

    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_inside_res = r_out_inside;
    assign o_iter_count = r_out_count;
    assign o_shade      = r_out_shade;

endmodule

// ----- rtl/met_ctrl.sv -----
module met_ctrl import met_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_CLAMP,
        S_SNAP,
        S_TEST,
        S_MUL_T,
        S_SQ_START,
        S_MUL_X,
        S_MUL_Y,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_SNAP;
            end
            S_SNAP: begin
                o_cmd.snap = 1'b1;
                n_state    = S_TEST;
            end
            S_TEST: begin
                if (i_sts.go) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_XY;
                    n_state         = S_MUL_T;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL_T: begin
                if (i_sts.mul_done) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_SQ_START;
                end
            end
            S_SQ_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_XX;
                n_state         = S_MUL_X;
            end
            S_MUL_X: begin
                if (i_sts.mul_done) begin
                    o_cmd.set_zx2   = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_YY;
                    n_state         = S_MUL_Y;
                end
            end
            S_MUL_Y: begin
                if (i_sts.mul_done) begin
                    o_cmd.set_zy2 = 1'b1;
                    n_state       = S_TEST;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/mandelbrot_escape_time_unit.sv -----
// Escape-time engine: one pixel transaction in, one result transaction out.
// Input channel (i_valid/o_ready) takes a pixel column and row; the pixel is
// mapped to c = origin + index * step and z = z*z + c is iterated from zero
// until |z|^2 reaches the escape square or the iteration limit is hit.
// Output channel (o_valid/i_ready) returns the indices, the inside flag,
// the iteration count n and the shade.
// All three products of an iteration share one 36x19 multiplier, which forms
// each product from a low-half and a high-half partial product and then
// sums, scales and saturates them.
// One pixel is in work at a time: no new pixel is taken until the current
// one is finished, and the next can be taken in the cycle after the result
// moves to the output register.
// A stalled receiver holds the result in the output register while the
// next pixel is taken and iterated; that pixel then waits until the
// register is free. Reset clears the controller, drops o_valid and loads
// the register reset values. The user must write registers over the APB
// port only while idle; the block itself does not enforce it.
module mandelbrot_escape_time_unit import met_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [COORD_BITS-1:0]    i_pixel_col,
    input  logic [COORD_BITS-1:0]    i_pixel_row,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [COORD_BITS-1:0]    o_out_col,
    output logic [COORD_BITS-1:0]    o_out_row,
    output logic                     o_inside_res,
    output logic [ITER_BITS-1:0]     o_iter_count,
    output logic [SHADE_BITS-1:0]    o_shade,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    met_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    met_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    met_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_inside_res (o_inside_res),
        .o_iter_count (o_iter_count),
        .o_shade      (o_shade)
    );

endmodule

// ----- rtl/met_checker.sv -----
module met_checker import met_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [COORD_BITS-1:0] o_out_col,
    input logic [COORD_BITS-1:0] o_out_row,
    input logic                  o_inside_res,
    input logic [ITER_BITS-1:0]  o_iter_count,
    input logic [SHADE_BITS-1:0] o_shade
);

    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after an input transaction");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_col) && $stable(o_out_row)
            && $stable(o_inside_res) && $stable(o_iter_count) && $stable(o_shade)))
        else $error("stalled result changed");

    a_outside_unshaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_res) |-> (o_shade == '0))
        else $error("escaped pixel carries a shade");

    a_reset_drops_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (.*);

// ----- verif/tb_mandelbrot_escape_time_unit.sv -----
module tb_mandelbrot_escape_time_unit;
    import met_pkg::*;

    localparam longint WORD_HI = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint WORD_LO = -WORD_HI - 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  in_set;
        logic [ITER_BITS-1:0]  count;
        logic [SHADE_BITS-1:0] shade;
    } t_pixel_res;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [COORD_BITS-1:0]    i_pixel_col = '0;
    logic [COORD_BITS-1:0]    i_pixel_row = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [COORD_BITS-1:0]    o_out_col;
    logic [COORD_BITS-1:0]    o_out_row;
    logic                     o_inside_res;
    logic [ITER_BITS-1:0]     o_iter_count;
    logic [SHADE_BITS-1:0]    o_shade;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int settings_loaded = 0;

    function automatic t_cfg reset_settings();
        t_cfg c;
        c.iter_limit   = ITER_LIMIT_RST;
        c.esc_square   = ESC_SQUARE_RST;
        c.origin_real  = ORIGIN_REAL_RST;
        c.origin_imag  = ORIGIN_IMAG_RST;
        c.step_real    = STEP_REAL_RST;
        c.step_imag    = STEP_IMAG_RST;
        c.inside_shade = INSIDE_SHADE_RST;
        return c;
    endfunction

    class pixel_scoreboard;
        t_cfg       cfg;
        t_pixel_res pending_results[$];
        int         errors;
        int         checked;
        int         in_set_seen;
        int         snapped;

        function new();
            cfg = reset_settings();
        endfunction

        function longint clamp_word(longint v);
            if (v > WORD_HI) return WORD_HI;
            if (v < WORD_LO) return WORD_LO;
            return v;
        endfunction

        function longint mul_fix(longint a, longint b);
            logic signed [PROD_BITS-1:0] wa;
            logic signed [PROD_BITS-1:0] wb;
            logic signed [PROD_BITS-1:0] prod;
            wa = a;
            wb = b;
            prod = (wa * wb) >>> FRAC_BITS;
            if (prod > WORD_HI) return WORD_HI;
            if (prod < WORD_LO) return WORD_LO;
            return longint'(prod);
        endfunction

        function t_pixel_res escape_count(logic [COORD_BITS-1:0] col,
                                          logic [COORD_BITS-1:0] row);
            t_pixel_res r;
            longint cx, cy, acy, zx, zy, zx2, zy2, t, n;
            cx = clamp_word(longint'($signed(cfg.origin_real))
                            + longint'(col) * longint'(cfg.step_real));
            cy = clamp_word(longint'($signed(cfg.origin_imag))
                            + longint'(row) * longint'(cfg.step_imag));
            acy = (cy < 0) ? -cy : cy;
            if (2 * acy < longint'(cfg.step_imag)) begin
                cy = 0;
                snapped++;
            end
            zx = 0;
            zy = 0;
            zx2 = 0;
            zy2 = 0;
            n = 0;
            while (n < longint'(cfg.iter_limit) && zx2 + zy2 < longint'(cfg.esc_square)) begin
                t = mul_fix(zx, zy);
                zy = clamp_word(2 * t + cy);
                zx = clamp_word(zx2 - zy2 + cx);
                zx2 = mul_fix(zx, zx);
                zy2 = mul_fix(zy, zy);
                n++;
            end
            r.col = col;
            r.row = row;
            r.in_set = (n == longint'(cfg.iter_limit));
            r.count = ITER_BITS'(n);
            r.shade = r.in_set ? cfg.inside_shade : '0;
            return r;
        endfunction

        function void note_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row);
            pending_results.push_back(escape_count(col, row));
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(t_pixel_res got);
            t_pixel_res want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction: expected none, actual col %0d row %0d",
                         $time, got.col, got.row);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (want.in_set) in_set_seen++;
            compare_field("out_col", want.col, got.col);
            compare_field("out_row", want.row, got.row);
            compare_field("inside_res", want.in_set, got.in_set);
            compare_field("iter_count", want.count, got.count);
            compare_field("shade", want.shade, got.shade);
        endfunction
    endclass

    pixel_scoreboard sb = new();

    mandelbrot_escape_time_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_inside_res (o_inside_res),
        .o_iter_count (o_iter_count),
        .o_shade      (o_shade),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_pixel(i_pixel_col, i_pixel_row);
            if (o_valid && i_ready) begin
                sb.check_result(t_pixel_res'{o_out_col, o_out_row, o_inside_res,
                                             o_iter_count, o_shade});
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'(idx) << ADDR_LSB;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ITER_LIMIT:   sb.cfg.iter_limit   = value[ITER_BITS-1:0];
            REG_ESC_SQUARE:   sb.cfg.esc_square   = value[ESC_BITS-1:0];
            REG_ORIGIN_REAL:  sb.cfg.origin_real  = value[WORD_BITS-1:0];
            REG_ORIGIN_IMAG:  sb.cfg.origin_imag  = value[WORD_BITS-1:0];
            REG_STEP_REAL:    sb.cfg.step_real    = value[STEP_BITS-1:0];
            REG_STEP_IMAG:    sb.cfg.step_imag    = value[STEP_BITS-1:0];
            REG_INSIDE_SHADE: sb.cfg.inside_shade = value[SHADE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(REG_ITER_LIMIT, APB_DATA_BITS'(c.iter_limit));
        write_reg(REG_ESC_SQUARE, APB_DATA_BITS'(c.esc_square));
        write_reg(REG_ORIGIN_REAL, APB_DATA_BITS'($signed(c.origin_real)));
        write_reg(REG_ORIGIN_IMAG, APB_DATA_BITS'($signed(c.origin_imag)));
        write_reg(REG_STEP_REAL, APB_DATA_BITS'(c.step_real));
        write_reg(REG_STEP_IMAG, APB_DATA_BITS'(c.step_imag));
        write_reg(REG_INSIDE_SHADE, APB_DATA_BITS'(c.inside_shade));
        settings_loaded++;
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct && gap < 40) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        longint ax;
        for (int i = 0; i < count; i++) begin
            col = COORD_BITS'($urandom);
            row = COORD_BITS'($urandom);
            if ($urandom_range(7) == 0 && sb.cfg.step_imag != 0) begin
                ax = -longint'($signed(sb.cfg.origin_imag)) / longint'(sb.cfg.step_imag)
                     + longint'($urandom_range(1));
                if (ax >= 0 && ax < (1 << COORD_BITS)) row = COORD_BITS'(ax);
            end
            send_pixel(col, row);
        end
        end_burst();
    endtask

    task automatic run_phase(input t_cfg c, input int gap, input int stall, input int count);
        load_settings(c);
        gap_pct = gap;
        stall_pct = stall;
        send_random(count);
        wait_drained();
    endtask

    function automatic t_cfg typical_settings(int max_limit);
        t_cfg c;
        c.iter_limit = ITER_BITS'($urandom_range(max_limit, 1));
        if ($urandom_range(3) == 0) begin
            c.esc_square = {ESC_BITS{1'b1}};
        end else begin
            c.esc_square = ESC_BITS'($urandom_range(32'h8000_0000, 32'h0100_0000));
        end
        c.origin_real  = -t_word'($urandom_range(3 << 28, 1 << 28));
        c.origin_imag  = -t_word'($urandom_range(3 << 27, 1 << 27));
        c.step_real    = STEP_BITS'($urandom_range(1 << 18, 1 << 14));
        c.step_imag    = STEP_BITS'($urandom_range(1 << 18, 1 << 14));
        c.inside_shade = SHADE_BITS'($urandom);
        return c;
    endfunction

    function automatic t_cfg wide_settings();
        t_cfg c;
        c.iter_limit   = ITER_BITS'($urandom_range(48, 0));
        c.esc_square   = ESC_BITS'({$urandom, $urandom});
        c.origin_real  = t_word'({$urandom, $urandom});
        c.origin_imag  = t_word'({$urandom, $urandom});
        c.step_real    = STEP_BITS'({$urandom, $urandom});
        c.step_imag    = STEP_BITS'({$urandom, $urandom});
        c.inside_shade = SHADE_BITS'($urandom);
        return c;
    endfunction

    function automatic t_cfg far_settings();
        t_cfg c;
        if ($urandom_range(1) == 0) begin
            c.iter_limit = '1;
        end else begin
            c.iter_limit = ITER_BITS'($urandom_range(65535, 1000));
        end
        c.esc_square   = ESC_BITS'($urandom);
        c.origin_real  = t_word'($urandom_range(32'hFFFF_FFFF, 3 << 28));
        c.origin_imag  = t_word'($signed($urandom));
        c.step_real    = STEP_BITS'($urandom_range(1 << 20, 0));
        c.step_imag    = STEP_BITS'($urandom_range(1 << 20, 0));
        c.inside_shade = SHADE_BITS'($urandom);
        return c;
    endfunction

    initial begin
        t_cfg c;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(375, 300);
        send_pixel(150, 300);
        send_pixel(300, 299);
        send_pixel(300, 301);
        end_burst();
        wait_drained();

        c = reset_settings();
        c.iter_limit = '0;
        load_settings(c);
        send_pixel(375, 300);
        send_pixel(4095, 4095);
        end_burst();
        wait_drained();

        c = reset_settings();
        c.esc_square = '0;
        load_settings(c);
        send_pixel(375, 300);
        send_pixel(4095, 4095);
        end_burst();
        wait_drained();

        c.iter_limit   = '1;
        c.esc_square   = '1;
        c.origin_real  = t_word'(WORD_HI);
        c.origin_imag  = t_word'(WORD_LO);
        c.step_real    = '1;
        c.step_imag    = '1;
        c.inside_shade = '1;
        load_settings(c);
        send_pixel(0, 0);
        send_pixel(0, 1);
        send_pixel(0, 2);
        send_pixel(4095, 4095);
        send_pixel(4095, 1);
        end_burst();
        wait_drained();

        c.origin_real  = t_word'(WORD_LO);
        c.origin_imag  = t_word'(WORD_HI);
        c.step_real    = '0;
        c.step_imag    = '0;
        c.inside_shade = '0;
        load_settings(c);
        send_pixel(4095, 0);
        send_pixel(123, 4095);
        end_burst();
        wait_drained();

        run_phase(typical_settings(48), 0, 0, 60);
        run_phase(typical_settings(48), 74, 0, 60);
        run_phase(typical_settings(48), 0, 74, 60);
        run_phase(typical_settings(48), 9, 9, 50);
        run_phase(wide_settings(), 0, 74, 40);

        load_settings(typical_settings(12));
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 2500;
        send_random(6);
        wait_drained();

        run_phase(reset_settings(), 0, 0, 12);
        run_phase(far_settings(), 9, 9, 40);
        run_phase(wide_settings(), 74, 0, 40);
        run_phase(typical_settings(24), 9, 9, 40);

        repeat (1000) @(posedge i_clk);
        $display("covered %0d pixels, %0d in the set, %0d with the imaginary part snapped",
                 sb.checked, sb.in_set_seen, sb.snapped);
        $display("over %0d register settings incl. zero/full-scale limits and a long output stall",
                 settings_loaded);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.errors,
                     sb.pending_results.size());
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", sb.pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- mandelbrot_escape_time_unit.f -----
rtl/met_pkg.sv
rtl/met_regs.sv
rtl/met_fxmul.sv
rtl/met_datapath.sv
rtl/met_ctrl.sv
rtl/mandelbrot_escape_time_unit.sv
rtl/met_checker.sv
verif/tb_mandelbrot_escape_time_unit.sv
